@@ rtl/vbot_pkg.sv @@
// ----------------------------------------------------------------------------
// vbot_pkg
// Shared types and constants for the voxel box occupancy table.
// ----------------------------------------------------------------------------
package vbot_pkg;

    localparam int MAX_OBJECTS_DEF = 64;
    localparam int MAX_MODELS_DEF  = 64;

    localparam logic [2:0] OP_REG   = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_REM   = 3'd2;
    localparam logic [2:0] OP_CLR   = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic [5:0]         model_index;
        logic signed [19:0] a_x;
        logic signed [19:0] a_y;
        logic signed [19:0] a_z;
        logic signed [19:0] b_x;
        logic signed [19:0] b_y;
        logic signed [19:0] b_z;
        logic [11:0]        scale_factor;
        logic               mob_blocks;
        logic               gas_blocks;
        logic [31:0]        object_id;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] new_id;
        logic        mob_blocked;
        logic        gas_blocked;
    } t_out_beat;

    // beat traveling down the cell chain
    typedef struct packed {
        logic               vld;
        logic [2:0]         op;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic               q_out;    // query coordinate outside 16-bit range
        logic [31:0]        id;       // id to remove, or new id
        logic [95:0]        box;      // lx ly lz hx hy hz
        logic [1:0]         flags;
        logic               done;     // add or remove already consumed
        logic               mob;
        logic               gas;
    } t_chain;

    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        if (v > 40'sd32767)
            return 16'sd32767;
        else if (v < -40'sd32768)
            return -16'sd32768;
        else
            return v[15:0];
    endfunction

endpackage

@@ rtl/vbot_cell.sv @@
// ----------------------------------------------------------------------------
// vbot_cell
// One object slot: holds a box, flags and id, and acts on the passing beat.
// ----------------------------------------------------------------------------
module vbot_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vbot_pkg::t_chain  i_beat,
    output vbot_pkg::t_chain  o_beat
);

    logic               r_used;
    logic signed [15:0] r_lo [3];
    logic signed [15:0] r_hi [3];
    logic [1:0]         r_flags;
    logic [31:0]        r_id;
    vbot_pkg::t_chain   r_beat;
    vbot_pkg::t_chain   n_beat;
    logic               n_used;
    logic               hit_box;
    logic               take;

    always_comb begin
        hit_box = !i_beat.q_out
            && i_beat.qx >= r_lo[0] && i_beat.qx <= r_hi[0]
            && i_beat.qy >= r_lo[1] && i_beat.qy <= r_hi[1]
            && i_beat.qz >= r_lo[2] && i_beat.qz <= r_hi[2];
        n_beat = i_beat;
        n_used = r_used;
        take   = 1'b0;
        if (i_beat.vld) begin
            case (i_beat.op)
                vbot_pkg::OP_ADD: begin
                    if (!i_beat.done && !r_used) begin
                        take        = 1'b1;
                        n_used      = 1'b1;
                        n_beat.done = 1'b1;
                    end
                end
                vbot_pkg::OP_REM: begin
                    if (!i_beat.done && r_used && r_id == i_beat.id) begin
                        n_used      = 1'b0;
                        n_beat.done = 1'b1;
                    end
                end
                vbot_pkg::OP_CLR: n_used = 1'b0;
                vbot_pkg::OP_QUERY: begin
                    if (r_used && hit_box) begin
                        n_beat.mob = i_beat.mob | r_flags[0];
                        n_beat.gas = i_beat.gas | r_flags[1];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= 1'b0;
            r_beat.vld <= 1'b0;
        end else begin
            r_used     <= n_used;
            r_beat.vld <= n_beat.vld;
        end
        r_beat.op    <= n_beat.op;
        r_beat.qx    <= n_beat.qx;
        r_beat.qy    <= n_beat.qy;
        r_beat.qz    <= n_beat.qz;
        r_beat.q_out <= n_beat.q_out;
        r_beat.id    <= n_beat.id;
        r_beat.box   <= n_beat.box;
        r_beat.flags <= n_beat.flags;
        r_beat.done  <= n_beat.done;
        r_beat.mob   <= n_beat.mob;
        r_beat.gas   <= n_beat.gas;
        if (take) begin
            r_lo[0] <= i_beat.box[95:80];
            r_lo[1] <= i_beat.box[79:64];
            r_lo[2] <= i_beat.box[63:48];
            r_hi[0] <= i_beat.box[47:32];
            r_hi[1] <= i_beat.box[31:16];
            r_hi[2] <= i_beat.box[15:0];
            r_flags <= i_beat.flags;
            r_id    <= i_beat.id;
        end
    end

    assign o_beat = r_beat;

endmodule

@@ rtl/vbot_box_calc.sv @@
// ----------------------------------------------------------------------------
// vbot_box_calc
// Scales a model extent, offsets by the cell origin and floors to voxels.
// Two stages: multiply, then add, floor and saturate.
// ----------------------------------------------------------------------------
module vbot_box_calc (
    input  logic               i_clk,
    input  logic signed [19:0] i_cell,
    input  logic               i_half,
    input  logic signed [19:0] i_lo,
    input  logic signed [19:0] i_hi,
    input  logic [11:0]        i_scale,
    input  logic               i_known,
    output logic signed [15:0] o_lo,
    output logic signed [15:0] o_hi
);

    logic signed [32:0] r_plo;
    logic signed [32:0] r_phi;
    logic signed [19:0] r_cell;
    logic               r_half;
    logic               r_known;
    logic signed [39:0] wmin;
    logic signed [39:0] wmax;
    logic signed [23:0] flo;
    logic signed [23:0] fhi;

    always_ff @(posedge i_clk) begin
        r_plo   <= i_lo * $signed({1'b0, i_scale});
        r_phi   <= i_hi * $signed({1'b0, i_scale});
        r_cell  <= i_cell;
        r_half  <= i_half;
        r_known <= i_known;
    end

    always_comb begin
        wmin = (40'(r_cell) <<< 16) + 40'({r_half, 15'd0}) + 40'(r_plo);
        wmax = (40'(r_cell) <<< 16) + 40'({r_half, 15'd0}) + 40'(r_phi) - 40'sd1;
        flo  = wmin[39:16];
        fhi  = ($signed(wmax[39:16]) < flo) ? flo : wmax[39:16];
        if (r_known) begin
            o_lo = vbot_pkg::sat16(40'(flo));
            o_hi = vbot_pkg::sat16(40'(fhi));
        end else begin
            o_lo = vbot_pkg::sat16(40'(r_cell));
            o_hi = vbot_pkg::sat16(40'(r_cell));
        end
    end

endmodule

@@ rtl/voxel_box_occupancy_table.sv @@
// ----------------------------------------------------------------------------
// voxel_box_occupancy_table
// Model extent table plus a chain of object slot cells.
// Throughput: one item at a time; the beat walks the whole cell chain, so the
// next item is taken when the previous result has been delivered.
// Reset: synchronous active low; clears slot and extent valid bits and the
// id counter.
// ----------------------------------------------------------------------------
module voxel_box_occupancy_table #(
    parameter int MAX_OBJECTS = vbot_pkg::MAX_OBJECTS_DEF,
    parameter int MAX_MODELS  = vbot_pkg::MAX_MODELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  vbot_pkg::t_in_beat  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output vbot_pkg::t_out_beat o_data
);

    localparam int MW = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_CALC, S_RUN} t_state;

    t_state             r_state;
    vbot_pkg::t_in_beat r_in;
    logic [59:0]        r_ext_lo [MAX_MODELS];
    logic [59:0]        r_ext_hi [MAX_MODELS];
    logic [MAX_MODELS-1:0] r_known;
    logic [59:0]        r_rd_lo;
    logic [59:0]        r_rd_hi;
    logic               r_rd_known;
    logic [31:0]        r_id_ctr;
    logic               r_out_vld;
    vbot_pkg::t_out_beat r_out;
    vbot_pkg::t_out_beat n_out;
    logic               in_range;
    logic [MW-1:0]      midx;
    logic signed [15:0] blo [3];
    logic signed [15:0] bhi [3];
    vbot_pkg::t_chain   head;
    vbot_pkg::t_chain   chain [MAX_OBJECTS+1];
    vbot_pkg::t_chain   tail;

    assign o_ready  = (r_state == S_IDLE) && !r_out_vld;
    assign in_range = 32'(r_in.model_index) < 32'(MAX_MODELS);
    assign midx     = MW'(r_in.model_index);

    for (genvar k = 0; k < 3; k++) begin : g_axis
        vbot_box_calc u_calc (
            .i_clk   (i_clk),
            .i_cell  (k == 0 ? r_in.a_x : (k == 1 ? r_in.a_y : r_in.a_z)),
            .i_half  (k != 1),
            .i_lo    ($signed(r_rd_lo[59-20*k -: 20])),
            .i_hi    ($signed(r_rd_hi[59-20*k -: 20])),
            .i_scale (r_in.scale_factor),
            .i_known (r_rd_known),
            .o_lo    (blo[k]),
            .o_hi    (bhi[k])
        );
    end

    always_comb begin
        head       = '0;
        head.vld   = (r_state == S_CALC);
        head.op    = r_in.operation;
        head.qx    = r_in.a_x[15:0];
        head.qy    = r_in.a_y[15:0];
        head.qz    = r_in.a_z[15:0];
        head.q_out = ($signed(r_in.a_x) != $signed(r_in.a_x[15:0]))
            || ($signed(r_in.a_y) != $signed(r_in.a_y[15:0]))
            || ($signed(r_in.a_z) != $signed(r_in.a_z[15:0]));
        head.id    = (r_in.operation == vbot_pkg::OP_ADD) ? r_id_ctr : r_in.object_id;
        head.box   = {blo[0], blo[1], blo[2], bhi[0], bhi[1], bhi[2]};
        head.flags = {r_in.gas_blocks, r_in.mob_blocks};
    end

    assign chain[0] = head;

    for (genvar i = 0; i < MAX_OBJECTS; i++) begin : g_cell
        vbot_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (chain[i]),
            .o_beat  (chain[i+1])
        );
    end

    assign tail = chain[MAX_OBJECTS];

    always_comb begin
        n_out = '0;
        case (tail.op)
            vbot_pkg::OP_ADD: begin
                if (tail.done) n_out.new_id = tail.id;
                else           n_out.status = vbot_pkg::ST_FULL;
            end
            vbot_pkg::OP_REM: begin
                if (!tail.done) n_out.status = vbot_pkg::ST_NOTFOUND;
            end
            vbot_pkg::OP_QUERY: begin
                n_out.mob_blocked = tail.mob;
                n_out.gas_blocked = tail.gas;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid && o_ready)
            r_in <= i_data;
        if (r_state == S_READ) begin
            r_rd_lo    <= r_ext_lo[midx];
            r_rd_hi    <= r_ext_hi[midx];
            r_rd_known <= in_range && r_known[midx];
            if (r_in.operation == vbot_pkg::OP_REG && in_range) begin
                r_ext_lo[midx] <= {r_in.a_x, r_in.a_y, r_in.a_z};
                r_ext_hi[midx] <= {r_in.b_x, r_in.b_y, r_in.b_z};
            end
        end
        if (tail.vld)
            r_out <= n_out;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_known   <= '0;
            r_id_ctr  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid && o_ready) r_state <= S_READ;
                S_READ: begin
                    r_state <= S_MUL;
                    if (r_in.operation == vbot_pkg::OP_REG && in_range)
                        r_known[midx] <= 1'b1;
                end
                S_MUL:  r_state <= S_CALC;
                S_CALC: r_state <= S_RUN;
                S_RUN:  if (tail.vld) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (tail.vld) begin
                r_out_vld <= 1'b1;
                if (tail.op == vbot_pkg::OP_ADD && tail.done)
                    r_id_ctr <= r_id_ctr + 32'd1;
            end else if (r_out_vld && i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !o_ready) else $error("input taken while result pending");
    a_tail_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail.vld |-> r_state == S_RUN) else $error("chain beat outside run");
    a_id_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_id_ctr != $past(r_id_ctr) |-> $past(tail.vld))
        else $error("id counter moved without add");

endmodule
